// ----- hw/rtl/mfb_pkg.sv -----
// Shared types, constants and the bytewise CRC-32 update for the mesh frame builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mfb_pkg;

    // Frame limits
    localparam int MAX_PAYLOAD  = 117;
    localparam int HEADER_BYTES = 6;
    localparam int PAY_CNT_W    = 7;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST = 2'd3;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] msg_type;
        logic       last_byte;
        logic       empty_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
        logic       last_of_run;
        logic       overflow;
    } t_out;

    typedef struct packed {
        logic [7:0]  magic_byte;
        logic [15:0] network_id;
        logic [7:0]  self_address;
        logic [7:0]  broadcast_address;
    } t_cfg;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mesh_frame_builder_crc32_unit.sv -----
// Mesh frame builder, top level: one item in, 0 to 11 framed bytes out.
// The item is registered in the sequencer, and each byte in the output stage before the port.
// Throughput: one output beat per cycle while the sink is ready; an item sends one byte
// per step (a payload byte inside a frame, the header and a payload byte on frame open),
// through the single byte-wide CRC update in the sequencer; a dropped byte sends none.
// Reset: synchronous active low; clears frame state, CRC and config to defaults.
`default_nettype none

module mesh_frame_builder_crc32_unit import mfb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg cfg;
    logic emit, stage_ready;
    t_out beat;

    mfb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mfb_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_stage_ready (stage_ready),
        .o_emit        (emit),
        .o_beat        (beat)
    );

    mfb_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (emit),
        .o_ready (stage_ready),
        .i_data  (beat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mfb_cfg_regs.sv -----
// Configuration register file of the mesh frame builder: header field values.
// Depends on mfb_pkg.
`default_nettype none

module mfb_cfg_regs import mfb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Decode the register index and store the written field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_byte        <= 8'd0;
            r_cfg.network_id        <= 16'd0;
            r_cfg.self_address      <= 8'd0;
            r_cfg.broadcast_address <= 8'hFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAGIC:     r_cfg.magic_byte        <= i_cfg_wdata[7:0];
                CFG_NETWORK:   r_cfg.network_id        <= i_cfg_wdata;
                CFG_SELF:      r_cfg.self_address      <= i_cfg_wdata[7:0];
                CFG_BROADCAST: r_cfg.broadcast_address <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/mfb_seq.sv -----
// Frame sequencer: holds one input item, walks header, payload and CRC steps,
// one byte per cycle while the output stage takes it, and keeps the per-frame CRC, count and drop state.
// Depends on mfb_pkg.
`default_nettype none

module mfb_seq import mfb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    input  wire logic i_stage_ready,
    output logic      o_emit,
    output t_out      o_beat
);

    // Step codes
    localparam logic [3:0] ST_HDR0 = 4'd0;
    localparam logic [3:0] ST_HDR1 = 4'd1;
    localparam logic [3:0] ST_HDR2 = 4'd2;
    localparam logic [3:0] ST_HDR3 = 4'd3;
    localparam logic [3:0] ST_HDR4 = 4'd4;
    localparam logic [3:0] ST_HDR5 = 4'(HEADER_BYTES - 1);
    localparam logic [3:0] ST_PAY  = 4'd6;
    localparam logic [3:0] ST_CRC0 = 4'd7;
    localparam logic [3:0] ST_CRC1 = 4'd8;
    localparam logic [3:0] ST_CRC2 = 4'd9;
    localparam logic [3:0] ST_CRC3 = 4'd10;

    logic                 r_busy;
    t_in                  r_item;
    logic [3:0]           r_phase, n_phase;
    logic                 r_in_frame, n_in_frame;
    logic [31:0]          r_crc, n_crc;
    logic [PAY_CNT_W-1:0] r_count, n_count;
    logic                 r_dropped, n_dropped;

    logic        emit, add_crc, eof, last_step;
    logic [7:0]  out_byte;
    logic [31:0] crc_out;
    logic        adv, done, accept, frame_after;
    logic [3:0]  start_phase;

    assign crc_out = ~r_crc;

    // Step decode: byte to send and the frame state after this step
    always_comb begin
        emit       = 1'b0;
        add_crc    = 1'b0;
        eof        = 1'b0;
        last_step  = 1'b0;
        out_byte   = 8'd0;
        n_phase    = r_phase;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_in_frame = r_in_frame;
        unique case (r_phase)
            ST_HDR0: begin
                emit = 1'b1; add_crc = 1'b1;
                out_byte = i_cfg.magic_byte;
                n_in_frame = 1'b1;
                n_phase = ST_HDR1;
            end
            ST_HDR1: begin
                emit = 1'b1; add_crc = 1'b1;
                out_byte = r_item.msg_type;
                n_phase = ST_HDR2;
            end
            ST_HDR2: begin
                emit = 1'b1; add_crc = 1'b1;
                out_byte = i_cfg.network_id[15:8];
                n_phase = ST_HDR3;
            end
            ST_HDR3: begin
                emit = 1'b1; add_crc = 1'b1;
                out_byte = i_cfg.network_id[7:0];
                n_phase = ST_HDR4;
            end
            ST_HDR4: begin
                emit = 1'b1; add_crc = 1'b1;
                out_byte = i_cfg.self_address;
                n_phase = ST_HDR5;
            end
            ST_HDR5: begin
                emit = 1'b1; add_crc = 1'b1;
                out_byte = i_cfg.broadcast_address;
                n_phase = r_item.empty_frame ? ST_CRC0 : ST_PAY;
            end
            ST_PAY: begin
                // Keep the byte while under the limit, otherwise drop and flag
                if (r_count < PAY_CNT_W'(MAX_PAYLOAD)) begin
                    emit = 1'b1; add_crc = 1'b1;
                    out_byte = r_item.payload_byte;
                    n_count = r_count + PAY_CNT_W'(1);
                end else begin
                    n_dropped = 1'b1;
                end
                if (r_item.last_byte) begin
                    n_phase = ST_CRC0;
                end else begin
                    last_step = 1'b1;
                end
            end
            ST_CRC0: begin
                emit = 1'b1; out_byte = crc_out[7:0];
                n_phase = ST_CRC1;
            end
            ST_CRC1: begin
                emit = 1'b1; out_byte = crc_out[15:8];
                n_phase = ST_CRC2;
            end
            ST_CRC2: begin
                emit = 1'b1; out_byte = crc_out[23:16];
                n_phase = ST_CRC3;
            end
            ST_CRC3: begin
                emit = 1'b1; eof = 1'b1; last_step = 1'b1;
                out_byte = crc_out[31:24];
                n_in_frame = 1'b0;
                n_count = '0;
                n_dropped = 1'b0;
            end
            default: begin
                last_step = 1'b1;
            end
        endcase
    end

    // CRC next value: fold on header and payload bytes, restart after the trailer
    always_comb begin
        n_crc = r_crc;
        if (add_crc) begin
            n_crc = crc_byte(r_crc, out_byte);
        end else if (eof) begin
            n_crc = CRC_ONES;
        end
    end

    // Advance when the byte is taken downstream or no byte is sent
    assign adv    = r_busy && (!emit || i_stage_ready);
    assign done   = adv && last_step;
    assign o_in_ready = !r_busy || done;
    assign accept = i_in_valid && o_in_ready;

    // Entry step for a new item, from the frame state it will see
    assign frame_after = adv ? n_in_frame : r_in_frame;
    always_comb begin
        if (!frame_after) begin
            start_phase = ST_HDR0;
        end else if (!i_in_data.empty_frame) begin
            start_phase = ST_PAY;
        end else begin
            start_phase = ST_CRC0;
        end
    end

    // Item holding register and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= ST_HDR0;
        end else if (accept) begin
            r_busy  <= 1'b1;
            r_phase <= start_phase;
        end else if (done) begin
            r_busy  <= 1'b0;
        end else if (adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
    end

    // Per-frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= CRC_ONES;
            r_count    <= '0;
            r_dropped  <= 1'b0;
        end else if (adv) begin
            r_in_frame <= n_in_frame;
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_dropped  <= n_dropped;
        end
    end

    assign o_emit              = r_busy && emit;
    assign o_beat.frame_byte   = out_byte;
    assign o_beat.end_of_frame = eof;
    assign o_beat.last_of_run  = last_step;
    assign o_beat.overflow     = r_dropped;

endmodule

`default_nettype wire

// ----- hw/rtl/mfb_out_stage.sv -----
// Output register of the mesh frame builder: holds one beat toward the sink.
// Depends on mfb_pkg.
`default_nettype none

module mfb_out_stage import mfb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_out i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    logic r_valid;
    t_out r_data;

    // Load a new beat whenever the register is empty or being drained
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hw/rtl/mfb_checker.sv -----
// Port-level checks for the mesh frame builder, bound to the top level.
// Depends on mfb_pkg and mesh_frame_builder_crc32_unit.
`default_nettype none

module mfb_checker import mfb_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);

    // A stalled beat stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // A stalled beat keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Frame end is always the final byte of its item
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_frame |-> o_out_data.last_of_run)
        else $error("end of frame without last of run");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind mesh_frame_builder_crc32_unit mfb_checker u_mfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- sim/tb_mesh_frame_builder_crc32_unit.sv -----
// Self-checking bench for the mesh frame builder: drives payload beats and register writes,
// predicts header, payload and CRC-32 trailer bytes in-bench and checks every output beat.
// Depends on mfb_pkg and mesh_frame_builder_crc32_unit from the RTL tree.

module tb_mesh_frame_builder_crc32_unit import mfb_pkg::*;;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    t_in                   in_beat   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_beat;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_MAGIC;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the header registers, reset values
    logic [7:0]  sh_magic     = 8'h00;
    logic [15:0] sh_network   = 16'h0000;
    logic [7:0]  sh_self      = 8'h00;
    logic [7:0]  sh_broadcast = 8'hFF;

    // Frame state of the predictor
    logic        fb_open    = 1'b0;
    logic [31:0] fb_crc     = CRC_ONES;
    int          fb_count   = 0;
    logic        fb_dropped = 1'b0;

    t_in  items_pending[$];
    t_out frame_beats_due[$];

    int items_queued   = 0;
    int items_accepted = 0;
    int beats_checked  = 0;
    int frames_closed  = 0;
    int frames_clipped = 0;
    int mismatches     = 0;
    int phases_run     = 0;

    int in_gap   = 0;
    int in_calm  = 0;
    int out_stall = 0;
    int out_calm  = 0;

    mesh_frame_builder_crc32_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Toggle the clock every half period
    always #5 i_clk = ~i_clk;

    // Fold one byte into a reflected CRC-32, one data bit per step
    function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Queue one expected frame byte, optionally folding it into the CRC
    function automatic void push_frame_byte(input logic [7:0] b, input logic eof,
                                            input logic fold);
        t_out o;
        if (fold) begin
            fb_crc = crc32_fold(fb_crc, b);
        end
        o.frame_byte   = b;
        o.end_of_frame = eof;
        o.last_of_run  = 1'b0;
        o.overflow     = fb_dropped;
        frame_beats_due.push_back(o);
    endfunction

    // Work out the frame bytes that one accepted input beat produces
    function automatic void predict_frame_beats(input t_in item);
        int          n_before;
        logic [31:0] fcs;
        n_before = frame_beats_due.size();
        // open a frame: header first
        if (!fb_open) begin
            fb_crc     = CRC_ONES;
            fb_count   = 0;
            fb_dropped = 1'b0;
            fb_open    = 1'b1;
            push_frame_byte(sh_magic, 1'b0, 1'b1);
            push_frame_byte(item.msg_type, 1'b0, 1'b1);
            push_frame_byte(sh_network[15:8], 1'b0, 1'b1);
            push_frame_byte(sh_network[7:0], 1'b0, 1'b1);
            push_frame_byte(sh_self, 1'b0, 1'b1);
            push_frame_byte(sh_broadcast, 1'b0, 1'b1);
        end
        // pass the payload byte, or drop it past the limit
        if (!item.empty_frame) begin
            if (fb_count < MAX_PAYLOAD) begin
                fb_count++;
                push_frame_byte(item.payload_byte, 1'b0, 1'b1);
            end else begin
                fb_dropped = 1'b1;
            end
        end
        // close: trailer LSB first
        if (item.last_byte || item.empty_frame) begin
            fcs = ~fb_crc;
            push_frame_byte(fcs[7:0], 1'b0, 1'b0);
            push_frame_byte(fcs[15:8], 1'b0, 1'b0);
            push_frame_byte(fcs[23:16], 1'b0, 1'b0);
            push_frame_byte(fcs[31:24], 1'b1, 1'b0);
            frames_closed++;
            if (fb_dropped) begin
                frames_clipped++;
            end
            fb_open    = 1'b0;
            fb_crc     = CRC_ONES;
            fb_count   = 0;
            fb_dropped = 1'b0;
        end
        if (frame_beats_due.size() > n_before) begin
            frame_beats_due[frame_beats_due.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    // Idle length: mostly none, some short, a few long, with calm streaks
    function automatic int draw_pause(input int calm_in, output int calm_out);
        int r;
        r = $urandom_range(0, 99);
        calm_out = 0;
        if (calm_in > 0) begin
            calm_out = calm_in - 1;
            return 0;
        end
        if (r < 6) begin
            calm_out = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at beat %0d: %s got %h expected %h",
                     beats_checked, what, got, want);
        end
    endtask

    // Input driver: present pending beats, predict on each accepted one
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            in_gap     = 0;
            fb_open    = 1'b0;
            fb_crc     = CRC_ONES;
            fb_count   = 0;
            fb_dropped = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_frame_beats(in_beat);
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap   = in_gap - 1;
                end else if (items_pending.size() > 0) begin
                    in_valid <= 1'b1;
                    in_beat  <= items_pending.pop_front();
                    in_gap   = draw_pause(in_calm, in_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure: random stalls of the frame byte stream
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_stall = 0;
        end else if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall = out_stall - 1;
        end else begin
            out_ready <= 1'b1;
            out_stall = draw_pause(out_calm, out_calm);
        end
    end

    // Monitor: check each accepted frame byte against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (frame_beats_due.size() == 0) begin
                report_mismatch("unexpected beat, frame_byte", out_beat.frame_byte, 8'h00);
            end else begin
                want = frame_beats_due.pop_front();
                if (out_beat.frame_byte !== want.frame_byte) begin
                    report_mismatch("frame_byte", out_beat.frame_byte, want.frame_byte);
                end
                if (out_beat.end_of_frame !== want.end_of_frame) begin
                    report_mismatch("end_of_frame", 8'(out_beat.end_of_frame),
                                    8'(want.end_of_frame));
                end
                if (out_beat.last_of_run !== want.last_of_run) begin
                    report_mismatch("last_of_run", 8'(out_beat.last_of_run),
                                    8'(want.last_of_run));
                end
                if (out_beat.overflow !== want.overflow) begin
                    report_mismatch("overflow", 8'(out_beat.overflow), 8'(want.overflow));
                end
            end
            beats_checked++;
        end
    end

    function automatic t_in make_item(input logic [7:0] p, input logic [7:0] t,
                                      input logic last, input logic empty);
        t_in it;
        it.payload_byte = p;
        it.msg_type     = t;
        it.last_byte    = last;
        it.empty_frame  = empty;
        return it;
    endfunction

    task automatic queue_item(input t_in it);
        items_pending.push_back(it);
        items_queued++;
    endtask

    // Queue a frame of len payload beats, closed by last mark or by an empty beat
    task automatic queue_frame(input int len, input bit close_empty);
        for (int i = 0; i < len; i++) begin
            queue_item(make_item(8'($urandom), 8'($urandom),
                                 !close_empty && (i == len - 1), 1'b0));
        end
        if (close_empty) begin
            queue_item(make_item(8'($urandom), 8'($urandom), 1'($urandom), 1'b1));
        end
    endtask

    task automatic queue_random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            queue_frame(0, 1'b1);
        end else if (r < 22) begin
            queue_frame($urandom_range(1, 6), 1'b1);
        end else if (r < 28) begin
            queue_frame($urandom_range(25, 45), 1'b0);
        end else begin
            queue_frame($urandom_range(1, 10), 1'b0);
        end
    endtask

    // Write one register; upper data bits carry noise for the byte-wide ones
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MAGIC:     sh_magic     = val[7:0];
            CFG_NETWORK:   sh_network   = val;
            CFG_SELF:      sh_self      = val[7:0];
            CFG_BROADCAST: sh_broadcast = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_header_regs(input logic [7:0] m, input logic [15:0] n,
                                     input logic [7:0] s, input logic [7:0] b);
        write_reg(CFG_MAGIC, {8'($urandom), m});
        write_reg(CFG_NETWORK, n);
        write_reg(CFG_SELF, {8'($urandom), s});
        write_reg(CFG_BROADCAST, {8'($urandom), b});
    endtask

    // Hold until every beat is in and every frame byte is out, then let the block settle
    task automatic wait_drained();
        while (items_pending.size() != 0 || in_valid || frame_beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        phases_run++;
    endtask

    // Give up after a generous fixed time
    initial begin
        #10_000_000;
        $display("timeout: %0d items accepted, %0d frame bytes outstanding",
                 items_accepted, frame_beats_due.size());
        $display("status: fail");
        $finish;
    end

    // Stimulus sequence and final verdict
    initial begin
        int phase_start;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed, reset register values
        queue_item(make_item(8'hFF, 8'h00, 1'b0, 1'b1));   // empty frame from idle
        queue_item(make_item(8'h00, 8'hFF, 1'b1, 1'b1));   // empty and last together
        queue_item(make_item(8'h00, 8'hFF, 1'b0, 1'b0));
        queue_item(make_item(8'hFF, 8'h00, 1'b0, 1'b0));
        queue_item(make_item(8'h5A, 8'hA5, 1'b1, 1'b0));
        queue_item(make_item(8'hA5, 8'h5A, 1'b1, 1'b0));   // one-byte frame
        queue_item(make_item(8'h3C, 8'h81, 1'b0, 1'b0));
        queue_item(make_item(8'hC3, 8'h7E, 1'b0, 1'b1));   // empty closes an open frame
        queue_item(make_item(8'h01, 8'h80, 1'b0, 1'b0));
        queue_item(make_item(8'h80, 8'h01, 1'b0, 1'b0));
        queue_item(make_item(8'h7F, 8'hFE, 1'b1, 1'b1));   // empty and last inside a frame
        wait_drained();

        // all-ones header but for a zero broadcast address, frame running past the payload limit
        write_header_regs(8'hFF, 16'hFFFF, 8'hFF, 8'h00);
        queue_frame(MAX_PAYLOAD + 3, 1'b0);
        queue_frame(1, 1'b0);
        queue_frame(3, 1'b1);
        wait_drained();

        // all-zero header, then random headers with random frame mixes
        while (items_queued < 410) begin
            if (phases_run == 2) begin
                write_header_regs(8'h00, 16'h0000, 8'h00, 8'h00);
            end else begin
                write_header_regs(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            end
            phase_start = items_queued;
            while (items_queued - phase_start < 55) begin
                queue_random_frame();
            end
            wait_drained();
        end

        $display("covered %0d input beats over %0d register settings", items_accepted,
                 phases_run);
        $display("checked %0d frame bytes in %0d frames (%0d clipped), %0d mismatches",
                 beats_checked, frames_closed, frames_clipped, mismatches);
        if (mismatches == 0 && frame_beats_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mfb_pkg.sv
hw/rtl/mfb_cfg_regs.sv
hw/rtl/mfb_seq.sv
hw/rtl/mfb_out_stage.sv
hw/rtl/mesh_frame_builder_crc32_unit.sv
hw/rtl/mfb_checker.sv
sim/tb_mesh_frame_builder_crc32_unit.sv
